/* rtl/sip_pkg.sv */
// Shared status constants for the segment intersection pipeline.
package sip_pkg;

    localparam logic [1:0] STATUS_FOUND   = 2'd0;
    localparam logic [1:0] STATUS_NONE    = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

endpackage

/* rtl/sip_div.sv */
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
module sip_div #(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 36,
    parameter int TAG_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [NUM_BITS-1:0] num,
    input  logic signed [DEN_BITS-1:0] den,
    input  logic [TAG_BITS-1:0]        tag_in,
    output logic                       out_valid,
    output logic signed [NUM_BITS-1:0] quo,
    output logic [TAG_BITS-1:0]        tag_out
);

    localparam int NS = NUM_BITS + 1;

    logic              v_reg   [NS];
    logic [NUM_BITS-1:0] q_reg [NS];
    logic [DEN_BITS:0]   r_reg [NS];
    logic [DEN_BITS-1:0] d_reg [NS];
    logic              neg_reg [NS];
    logic [TAG_BITS-1:0] t_reg [NS];

    logic [NUM_BITS-1:0] num_mag;
    logic [DEN_BITS-1:0] den_mag;

    always_comb
    begin
        num_mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
        den_mag = den[DEN_BITS-1] ? DEN_BITS'(-den) : DEN_BITS'(den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0]   <= num_mag;
            r_reg[0]   <= '0;
            d_reg[0]   <= den_mag;
            neg_reg[0] <= num[NUM_BITS-1] ^ den[DEN_BITS-1];
            t_reg[0]   <= tag_in;
            for (int i = 1; i < NS; i++)
            begin
                logic [DEN_BITS+1:0] sh;
                logic [DEN_BITS+1:0] df;
                sh = {r_reg[i-1], q_reg[i-1][NUM_BITS-1]};
                df = sh - {2'b00, d_reg[i-1]};
                if (!df[DEN_BITS+1])
                begin
                    r_reg[i] <= df[DEN_BITS:0];
                    q_reg[i] <= {q_reg[i-1][NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    r_reg[i] <= sh[DEN_BITS:0];
                    q_reg[i] <= {q_reg[i-1][NUM_BITS-2:0], 1'b0};
                end
                d_reg[i]   <= d_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                t_reg[i]   <= t_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign quo       = neg_reg[NS-1] ? -$signed(q_reg[NS-1]) : $signed(q_reg[NS-1]);
    assign tag_out   = t_reg[NS-1];

endmodule

/* rtl/segment_intersection_point.sv */
// Segment intersection: products, numerators, divider pipeline, bounding-box check.
// Pipeline from input transaction to m_tvalid: five front stages, 4*COORD_BITS+6
// divider stages, output register.
// Throughput: one transaction per cycle; the whole pipeline advances when the
// output register is free or taken.
// Reset: asynchronous active-low rst_n clears all valid bits.
module segment_intersection_point #(
    parameter int COORD_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // line_start_x, line_start_y, line_stop_x, line_stop_y,
    // shape_start_x, shape_start_y, shape_stop_x, shape_stop_y
    input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status, cross_x, cross_y
    output logic [((2+2*COORD_BITS+7)/8)*8-1:0] m_tdata
);
    import sip_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DF = C + 1;
    localparam int PR = 2 * DF;
    localparam int SM = PR + 1;
    localparam int NB = 2 * C + SM + 2;
    localparam int TB = 8 * C;
    localparam int OW = ((2 + 2 * C + 7) / 8) * 8;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: differences
    logic            v1_reg;
    logic [TB-1:0]   pt1_reg;
    logic signed [DF-1:0] cdx1_reg, aby1_reg, cdy1_reg, bax1_reg, cax1_reg, cay1_reg;
    logic signed [DF-1:0] dcx1_reg, dcy1_reg;
    logic            hor1_reg;

    logic signed [C-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    assign ax = s_tdata[0*C +: C];
    assign ay = s_tdata[1*C +: C];
    assign bx = s_tdata[2*C +: C];
    assign by = s_tdata[3*C +: C];
    assign cx = s_tdata[4*C +: C];
    assign cy = s_tdata[5*C +: C];
    assign dx = s_tdata[6*C +: C];
    assign dy = s_tdata[7*C +: C];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt1_reg  <= s_tdata[TB-1:0];
            cdx1_reg <= DF'(cx) - DF'(dx);
            aby1_reg <= DF'(ay) - DF'(by);
            cdy1_reg <= DF'(cy) - DF'(dy);
            bax1_reg <= DF'(bx) - DF'(ax);
            cax1_reg <= DF'(cx) - DF'(ax);
            cay1_reg <= DF'(cy) - DF'(ay);
            dcx1_reg <= DF'(dx) - DF'(cx);
            dcy1_reg <= DF'(dy) - DF'(cy);
            hor1_reg <= (ay == by);
        end
    end

    // stage 2: cross products
    logic            v2_reg;
    logic [TB-1:0]   pt2_reg;
    logic signed [PR-1:0] p0_2_reg, p1_2_reg, p2_2_reg, p3_2_reg;
    logic signed [DF-1:0] cdy2_reg, cay2_reg, dcx2_reg, dcy2_reg;
    logic            hor2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt2_reg  <= pt1_reg;
            p0_2_reg <= PR'(cdx1_reg) * PR'(aby1_reg);
            p1_2_reg <= PR'(cdy1_reg) * PR'(bax1_reg);
            p2_2_reg <= PR'(cax1_reg) * PR'(aby1_reg);
            p3_2_reg <= PR'(cay1_reg) * PR'(bax1_reg);
            cdy2_reg <= cdy1_reg;
            cay2_reg <= cay1_reg;
            dcx2_reg <= dcx1_reg;
            dcy2_reg <= dcy1_reg;
            hor2_reg <= hor1_reg;
        end
    end

    // stage 3: num and den
    logic            v3_reg;
    logic [TB-1:0]   pt3_reg;
    logic signed [SM-1:0] num3_reg, den3_reg;
    logic signed [DF-1:0] dcx3_reg, dcy3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt3_reg  <= pt2_reg;
            den3_reg <= hor2_reg ? SM'(cdy2_reg) : SM'(p0_2_reg) + SM'(p1_2_reg);
            num3_reg <= hor2_reg ? SM'(cay2_reg) : SM'(p2_2_reg) + SM'(p3_2_reg);
            dcx3_reg <= dcx2_reg;
            dcy3_reg <= dcy2_reg;
        end
    end

    // stage 4: numerator products
    logic            v4_reg;
    logic [TB-1:0]   pt4_reg;
    logic signed [SM-1:0] den4_reg;
    logic signed [NB-1:0] cxd4_reg, cyd4_reg, dxn4_reg, dyn4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt4_reg  <= pt3_reg;
            den4_reg <= den3_reg;
            cxd4_reg <= NB'($signed(pt3_reg[4*C +: C])) * NB'(den3_reg);
            cyd4_reg <= NB'($signed(pt3_reg[5*C +: C])) * NB'(den3_reg);
            dxn4_reg <= NB'(dcx3_reg) * NB'(num3_reg);
            dyn4_reg <= NB'(dcy3_reg) * NB'(num3_reg);
        end
    end

    // stage 5: sums
    logic            v5_reg;
    logic signed [NB-1:0] nx5_reg, ny5_reg;
    logic signed [SM-1:0] den5_reg;
    logic [TB-1:0]   pt5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx5_reg  <= cxd4_reg + dxn4_reg;
            ny5_reg  <= cyd4_reg + dyn4_reg;
            den5_reg <= den4_reg;
            pt5_reg  <= pt4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // divider: tag carries points and zero-denominator flag
    localparam int TG = TB + 1;
    logic            dvx, dvy;
    logic signed [NB-1:0] qx, qy;
    logic [TG-1:0]   tgx, tgy;
    logic signed [SM-1:0] den_safe;
    logic            den_zero;

    assign den_zero = (den5_reg == '0);
    assign den_safe = den_zero ? SM'(1) : den5_reg;

    sip_div #(.NUM_BITS(NB), .DEN_BITS(SM), .TAG_BITS(TG)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_reg),
        .num(nx5_reg), .den(den_safe), .tag_in({den_zero, pt5_reg}),
        .out_valid(dvx), .quo(qx), .tag_out(tgx)
    );

    sip_div #(.NUM_BITS(NB), .DEN_BITS(SM), .TAG_BITS(TG)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_reg),
        .num(ny5_reg), .den(den_safe), .tag_in({den_zero, pt5_reg}),
        .out_valid(dvy), .quo(qy), .tag_out(tgy)
    );

    // final: box check into output register
    logic signed [NB-1:0] bax_, bay_, bbx_, bby_, bcx_, bcy_, bdx_, bdy_;
    logic in_box;
    logic [1:0] st;
    logic [OW-1:0] out_next;
    logic [OW-1:0] out_reg;

    always_comb
    begin
        bax_ = NB'($signed(tgx[0*C +: C]));
        bay_ = NB'($signed(tgx[1*C +: C]));
        bbx_ = NB'($signed(tgx[2*C +: C]));
        bby_ = NB'($signed(tgx[3*C +: C]));
        bcx_ = NB'($signed(tgx[4*C +: C]));
        bcy_ = NB'($signed(tgx[5*C +: C]));
        bdx_ = NB'($signed(tgx[6*C +: C]));
        bdy_ = NB'($signed(tgx[7*C +: C]));
        in_box = ((qx >= bax_ && qx <= bbx_) || (qx >= bbx_ && qx <= bax_))
              && ((qy >= bay_ && qy <= bby_) || (qy >= bby_ && qy <= bay_))
              && ((qx >= bcx_ && qx <= bdx_) || (qx >= bdx_ && qx <= bcx_))
              && ((qy >= bcy_ && qy <= bdy_) || (qy >= bdy_ && qy <= bcy_));
        if (tgx[TB])
            st = STATUS_NONE;
        else if (!in_box)
            st = STATUS_OUTSIDE;
        else
            st = STATUS_FOUND;
        out_next = '0;
        out_next[1:0] = st;
        if (st == STATUS_FOUND)
        begin
            out_next[2 +: C]     = qx[C-1:0];
            out_next[2 + C +: C] = qy[C-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid <= dvx && dvy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

    logic unused;
    assign unused = ^tgy;

endmodule
